// ===== design/cdir_pkg.sv =====
package cdir_pkg;

   localparam int ADDR_W      = 32;
   localparam int WAY_OUT_W   = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_BACK_MODE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOCATE_ON_WRITE = 1'd1;

   typedef struct packed {
      logic write_back_mode;
      logic allocate_on_write;
   } cfg_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way_used;
      logic                 fill_request;
      logic                 victim_writeback;
      logic [ADDR_W-1:0]    victim_address;
      logic                 write_through;
      logic                 write_around;
   } rsp_type;

endpackage

// ===== design/cdir_front.sv =====
module cdir_front #(
   parameter int OFFSET_BITS = 6,
   parameter int SETS        = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     init_done,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_opcode,
   input  logic [cdir_pkg::ADDR_W-1:0]              req_address,
   output logic                                     push_valid,
   input  logic                                     push_ready,
   output logic [cdir_pkg::ADDR_W-OFFSET_BITS+
                 ((SETS > 1) ? $clog2(SETS) : 1)-
                 $clog2(SETS + 1)+1:0]              push_item
);

   localparam int ADDR_W   = cdir_pkg::ADDR_W;
   localparam int LINE_W   = ADDR_W - OFFSET_BITS;
   localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int TAG_W    = LINE_W - $clog2(SETS + 1) + 1;
   localparam bit SET_POW2 = (SETS & (SETS - 1)) == 0;

   logic              is_write;
   logic [LINE_W-1:0] lineno;

   assign is_write = req_opcode == cdir_pkg::OP_WRITE;
   assign lineno   = req_address[ADDR_W-1:OFFSET_BITS];

   if (SET_POW2) begin : g_shift
      logic [SET_W-1:0] set_idx;
      logic [TAG_W-1:0] tag;

      assign set_idx    = SET_W'(lineno % LINE_W'(SETS));
      assign tag        = TAG_W'(lineno / LINE_W'(SETS));
      assign req_stall  = !init_done || !push_ready;
      assign push_valid = req_valid && !req_stall;
      assign push_item  = {is_write, set_idx, tag};
   end else begin : g_divide
      typedef enum logic [1:0] {
         S_IDLE,
         S_QUOT,
         S_REM,
         S_PUSH
      } state_type;

      // The quotient comes from a rounded-up reciprocal, which is exact for every line number.
      localparam int                RECIP_SHIFT = LINE_W + SET_W;
      localparam longint unsigned   RECIP_VALUE =
         ((64'd1 << RECIP_SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS);
      localparam logic [LINE_W:0]   RECIP       = (LINE_W + 1)'(RECIP_VALUE);
      localparam logic [LINE_W-1:0] SETS_LINE   = LINE_W'(SETS);

      state_type           state_ff, state_in;
      logic [LINE_W-1:0]   line_ff, line_in;
      logic [TAG_W-1:0]    quot_ff, quot_in;
      logic [SET_W-1:0]    rem_ff, rem_in;
      logic                write_ff, write_in;
      logic [2*LINE_W:0]   product;

      assign product = (2*LINE_W+1)'(line_ff) * (2*LINE_W+1)'(RECIP);

      always_comb begin
         state_in = state_ff;
         line_in  = line_ff;
         quot_in  = quot_ff;
         rem_in   = rem_ff;
         write_in = write_ff;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && init_done) begin
                  line_in  = lineno;
                  write_in = is_write;
                  state_in = S_QUOT;
               end
            end
            S_QUOT: begin
               quot_in  = TAG_W'(product >> RECIP_SHIFT);
               state_in = S_REM;
            end
            S_REM: begin
               rem_in   = SET_W'(line_ff - LINE_W'(quot_ff) * SETS_LINE);
               state_in = S_PUSH;
            end
            S_PUSH: begin
               if (push_ready) begin
                  state_in = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            state_ff <= S_IDLE;
         end else begin
            state_ff <= state_in;
         end
         line_ff  <= line_in;
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
         write_ff <= write_in;
      end

      assign req_stall  = !(state_ff == S_IDLE && init_done);
      assign push_valid = state_ff == S_PUSH;
      assign push_item  = {write_ff, rem_ff, quot_ff};
   end

endmodule

// ===== design/cdir_queue.sv =====
module cdir_queue #(
   parameter int WIDTH = 27
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_item,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_item
);

   localparam int DEPTH = cdir_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/cdir_back.sv =====
module cdir_back #(
   parameter int OFFSET_BITS = 6,
   parameter int SETS        = 64,
   parameter int WAYS        = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  cdir_pkg::cfg_type                        cfg,
   output logic                                     init_done,
   input  logic                                     pop_valid,
   output logic                                     pop_ready,
   input  logic [cdir_pkg::ADDR_W-OFFSET_BITS+
                 ((SETS > 1) ? $clog2(SETS) : 1)-
                 $clog2(SETS + 1)+1:0]              pop_item,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output cdir_pkg::rsp_type                        rsp
);

   localparam int ADDR_W    = cdir_pkg::ADDR_W;
   localparam int WAY_OUT_W = cdir_pkg::WAY_OUT_W;
   localparam int LINE_W    = ADDR_W - OFFSET_BITS;
   localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int TAG_W     = LINE_W - $clog2(SETS + 1) + 1;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W    = WAY_W;
   localparam logic [RANK_W-1:0] TOP_RANK  = RANK_W'(WAYS - 1);
   localparam logic [LINE_W-1:0] SETS_LINE = LINE_W'(SETS);

   typedef struct packed {
      logic [WAYS-1:0]             valid;
      logic [WAYS-1:0]             dirty;
      logic [WAYS-1:0][TAG_W-1:0]  tag;
      logic [WAYS-1:0][RANK_W-1:0] rank;
   } row_type;

   row_type dir_mem [SETS];
   row_type rd_row_ff;

   row_type          fwd_row_ff, fwd_row_in;
   logic [SET_W-1:0] fwd_set_ff, fwd_set_in;
   logic             fwd_valid_ff, fwd_valid_in;

   logic             b_valid_ff, b_valid_in;
   logic             b_write_ff, b_write_in;
   logic [SET_W-1:0] b_set_ff, b_set_in;
   logic [TAG_W-1:0] b_tag_ff, b_tag_in;

   logic             clr_active_ff, clr_active_in;
   logic [SET_W-1:0] clr_set_ff, clr_set_in;

   logic              rsp_valid_ff, rsp_valid_in;
   cdir_pkg::rsp_type rsp_ff, rsp_in;

   logic              q_write;
   logic [SET_W-1:0]  q_set;
   logic [TAG_W-1:0]  q_tag;
   logic              b_fire;
   logic              issue;
   row_type           cur;
   row_type           new_row;
   logic              hit;
   logic              alloc;
   logic              around;
   logic              inv_any;
   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  inv_way;
   logic [WAY_W-1:0]  lru_way;
   logic [WAY_W-1:0]  vic_way;
   logic [WAY_W-1:0]  way;
   logic [RANK_W-1:0] old_rank;
   logic              victim_valid;
   logic [LINE_W-1:0] vline;
   cdir_pkg::rsp_type rsp_new;

   logic              wr_en;
   logic [SET_W-1:0]  wr_set;
   row_type           wr_row;

   assign {q_write, q_set, q_tag} = pop_item;

   assign init_done = !clr_active_ff;
   assign b_fire    = b_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop_ready = !clr_active_ff && (!b_valid_ff || b_fire);
   assign issue     = pop_valid && pop_ready;

   // The row written by the previous access is newer than what the memory returned.
   assign cur = (fwd_valid_ff && fwd_set_ff == b_set_ff) ? fwd_row_ff : rd_row_ff;

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      inv_any = 1'b0;
      inv_way = '0;
      lru_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (cur.valid[w] && cur.tag[w] == b_tag_ff) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!cur.valid[w]) begin
            inv_any = 1'b1;
            inv_way = WAY_W'(w);
         end
         if (cur.rank[w] == '0) begin
            lru_way = WAY_W'(w);
         end
      end
   end

   assign around  = !hit && b_write_ff && !cfg.allocate_on_write;
   assign alloc   = !hit && !around;
   assign vic_way = inv_any ? inv_way : lru_way;
   assign way     = hit ? hit_way : (alloc ? vic_way : '0);
   assign old_rank = cur.rank[way];

   always_comb begin
      new_row = cur;
      if (hit || alloc) begin
         for (int w = 0; w < WAYS; w++) begin
            if (cur.rank[w] > old_rank) begin
               new_row.rank[w] = cur.rank[w] - 1'b1;
            end
         end
         new_row.rank[way] = TOP_RANK;
         if (alloc) begin
            new_row.valid[way] = 1'b1;
            new_row.tag[way]   = b_tag_ff;
            new_row.dirty[way] = b_write_ff;
         end else if (b_write_ff) begin
            new_row.dirty[way] = 1'b1;
         end
      end
   end

   assign victim_valid = alloc && cur.valid[vic_way];
   assign vline        = LINE_W'(cur.tag[vic_way] * SETS_LINE) + LINE_W'(b_set_ff);

   always_comb begin
      rsp_new.hit              = hit;
      rsp_new.way_used         = WAY_OUT_W'(way);
      rsp_new.fill_request     = alloc;
      rsp_new.victim_writeback = victim_valid && cur.dirty[vic_way] && cfg.write_back_mode;
      rsp_new.victim_address   = victim_valid ? (ADDR_W'(vline) << OFFSET_BITS) : '0;
      rsp_new.write_through    = b_write_ff && (hit || alloc) && !cfg.write_back_mode;
      rsp_new.write_around     = around;
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_write_in = b_write_ff;
      b_set_in   = b_set_ff;
      b_tag_in   = b_tag_ff;
      if (issue) begin
         b_valid_in = 1'b1;
         b_write_in = q_write;
         b_set_in   = q_set;
         b_tag_in   = q_tag;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_set_in   = fwd_set_ff;
      fwd_row_in   = fwd_row_ff;
      if (b_fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_new;
         fwd_valid_in = 1'b1;
         fwd_set_in   = b_set_ff;
         fwd_row_in   = new_row;
      end

      clr_active_in = clr_active_ff;
      clr_set_in    = clr_set_ff;
      if (clr_active_ff) begin
         clr_set_in = clr_set_ff + 1'b1;
         if (clr_set_ff == SET_W'(SETS - 1)) begin
            clr_active_in = 1'b0;
         end
      end

      wr_en  = clr_active_ff || b_fire;
      wr_set = clr_active_ff ? clr_set_ff : b_set_ff;
      wr_row = clr_active_ff ? row_type'('0) : new_row;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dir_mem[wr_set] <= wr_row;
      end
      if (issue) begin
         rd_row_ff <= dir_mem[q_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_set_ff    <= '0;
      end else begin
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         clr_active_ff <= clr_active_in;
         clr_set_ff    <= clr_set_in;
      end
      b_write_ff <= b_write_in;
      b_set_ff   <= b_set_in;
      b_tag_ff   <= b_tag_in;
      rsp_ff     <= rsp_in;
      fwd_set_ff <= fwd_set_in;
      fwd_row_ff <= fwd_row_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== design/set_assoc_lru_cache_directory_core.sv =====
// Directory of a set-associative write-back/write-through cache with LRU replacement: each
// transfer on the req_ channel is a read or write to a byte address, and each yields exactly
// one transfer on the rsp_ channel giving hit, the way used, whether a fill and a victim
// write-back are needed, and whether the write goes through or around the cache. The
// directory is held one set per memory row; after reset a clearing pass zeroes every set,
// during which req_stall is high. With SETS a power of two the block takes one access per
// cycle while rsp_stall is low, limited by the single read-modify-write of a set row per
// cycle. Otherwise the set index and tag come from a reciprocal multiplication and a
// remainder step, and the request side takes no new access until the states S_QUOT,
// S_REM and S_PUSH have run and the access has entered the queue.
module set_assoc_lru_cache_directory_core #(
   parameter int OFFSET_BITS = 6,
   parameter int SETS        = 64,
   parameter int WAYS        = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [cdir_pkg::ADDR_W-1:0]          req_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [cdir_pkg::WAY_OUT_W-1:0]       rsp_way_used,
   output logic                                 rsp_fill_request,
   output logic                                 rsp_victim_writeback,
   output logic [cdir_pkg::ADDR_W-1:0]          rsp_victim_address,
   output logic                                 rsp_write_through,
   output logic                                 rsp_write_around,
   input  logic                                 csr_write_enable,
   input  logic [cdir_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cdir_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int LINE_W = cdir_pkg::ADDR_W - OFFSET_BITS;
   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int TAG_W  = LINE_W - $clog2(SETS + 1) + 1;
   localparam int ITEM_W = 1 + SET_W + TAG_W;

   cdir_pkg::cfg_type cfg_ff, cfg_in;
   cdir_pkg::rsp_type rsp;

   logic              init_done;
   logic              push_valid;
   logic              push_ready;
   logic [ITEM_W-1:0] push_item;
   logic              pop_valid;
   logic              pop_ready;
   logic [ITEM_W-1:0] pop_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cdir_pkg::CSR_WRITE_BACK_MODE: begin
               cfg_in.write_back_mode = csr_write_data[0];
            end
            cdir_pkg::CSR_ALLOCATE_ON_WRITE: begin
               cfg_in.allocate_on_write = csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.write_back_mode   <= 1'b1;
         cfg_ff.allocate_on_write <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cdir_front #(
      .OFFSET_BITS (OFFSET_BITS),
      .SETS        (SETS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .init_done   (init_done),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_address (req_address),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   cdir_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   cdir_back #(
      .OFFSET_BITS (OFFSET_BITS),
      .SETS        (SETS),
      .WAYS        (WAYS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .init_done (init_done),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_hit              = rsp.hit;
   assign rsp_way_used         = rsp.way_used;
   assign rsp_fill_request     = rsp.fill_request;
   assign rsp_victim_writeback = rsp.victim_writeback;
   assign rsp_victim_address   = rsp.victim_address;
   assign rsp_write_through    = rsp.write_through;
   assign rsp_write_around     = rsp.write_around;

endmodule

// ===== design/cdir_checker.sv =====
module cdir_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_hit,
   input logic [cdir_pkg::WAY_OUT_W-1:0] rsp_way_used,
   input logic                           rsp_fill_request,
   input logic                           rsp_victim_writeback,
   input logic [cdir_pkg::ADDR_W-1:0]    rsp_victim_address,
   input logic                           rsp_write_through,
   input logic                           rsp_write_around
);

   // Every response is exactly one of a hit, a fill or a write around the cache.
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_hit, rsp_fill_request, rsp_write_around}))
      else $error("response is not exactly one of hit, fill and write-around");

   a_around_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_around |-> rsp_way_used == '0 && !rsp_victim_writeback &&
                                        rsp_victim_address == '0 && !rsp_write_through)
      else $error("write-around response carries allocation fields");

   a_victim_needs_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_victim_writeback || rsp_victim_address != '0) |-> rsp_fill_request)
      else $error("victim reported without a fill");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_victim_address) &&
                                 $stable(rsp_way_used))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind set_assoc_lru_cache_directory_core cdir_checker u_cdir_checker (.*);

// ===== verif/tb_set_assoc_lru_cache_directory_core.sv =====
module tb_set_assoc_lru_cache_directory_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OFFSET_BITS   = 6;
   localparam int SETS          = 64;
   localparam int WAYS          = 4;
   localparam int SET_BITS      = 6;
   localparam int TAG_W         = cdir_pkg::ADDR_W - OFFSET_BITS - SET_BITS;
   localparam int LINES         = SETS * WAYS;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic                             req_opcode;
   logic [cdir_pkg::ADDR_W-1:0]      req_address;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic                             rsp_hit;
   logic [cdir_pkg::WAY_OUT_W-1:0]   rsp_way_used;
   logic                             rsp_fill_request;
   logic                             rsp_victim_writeback;
   logic [cdir_pkg::ADDR_W-1:0]      rsp_victim_address;
   logic                             rsp_write_through;
   logic                             rsp_write_around;
   logic                             csr_write_enable;
   logic [cdir_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cdir_pkg::CSR_DATA_W-1:0]  csr_write_data;

   logic                   line_present  [LINES];
   logic                   line_modified [LINES];
   logic [TAG_W-1:0]       line_tag_copy [LINES];
   logic [1:0]             line_rank     [LINES];
   cdir_pkg::cfg_type      mode;

   cdir_pkg::rsp_type      pending_outcomes [$];
   cdir_pkg::rsp_type      expected_rsp;
   int                     error_count   = 0;
   int                     cycle_count   = 0;
   int                     send_idle_pct = 0;
   int                     stall_pct     = 0;
   int                     hold_cycles   = 0;

   set_assoc_lru_cache_directory_core #(
      .OFFSET_BITS(OFFSET_BITS),
      .SETS(SETS),
      .WAYS(WAYS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_address(req_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_way_used(rsp_way_used),
      .rsp_fill_request(rsp_fill_request),
      .rsp_victim_writeback(rsp_victim_writeback),
      .rsp_victim_address(rsp_victim_address),
      .rsp_write_through(rsp_write_through),
      .rsp_write_around(rsp_write_around),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic cdir_pkg::rsp_type directory_lookup(cdir_pkg::opcode_type op,
                                                          logic [cdir_pkg::ADDR_W-1:0] addr);
      logic [SET_BITS-1:0] set_idx;
      logic [TAG_W-1:0]    tag;
      logic [1:0]          old_rank;
      logic                found;
      int                  base;
      int                  way;
      cdir_pkg::rsp_type   outcome;
      set_idx = addr[OFFSET_BITS +: SET_BITS];
      tag     = addr[cdir_pkg::ADDR_W-1 -: TAG_W];
      base    = set_idx * WAYS;
      found   = 1'b0;
      way     = 0;
      outcome = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && line_present[base+w] && line_tag_copy[base+w] == tag) begin
            found = 1'b1;
            way   = w;
         end
      end
      if (!found && op == cdir_pkg::OP_WRITE && !mode.allocate_on_write) begin
         outcome.write_around = 1'b1;
         return outcome;
      end
      if (found) begin
         outcome.hit = 1'b1;
         if (op == cdir_pkg::OP_WRITE) begin
            line_modified[base+way] = 1'b1;
         end
      end else begin
         way = -1;
         for (int w = 0; w < WAYS; w++) begin
            if (way < 0 && !line_present[base+w]) begin
               way = w;
            end
         end
         if (way < 0) begin
            way = 0;
            for (int w = 1; w < WAYS; w++) begin
               if (line_rank[base+w] < line_rank[base+way]) begin
                  way = w;
               end
            end
            outcome.victim_address   = {line_tag_copy[base+way], set_idx, {OFFSET_BITS{1'b0}}};
            outcome.victim_writeback = mode.write_back_mode && line_modified[base+way];
         end
         line_present[base+way]  = 1'b1;
         line_tag_copy[base+way] = tag;
         line_modified[base+way] = (op == cdir_pkg::OP_WRITE);
         outcome.fill_request    = 1'b1;
      end
      old_rank = line_rank[base+way];
      for (int w = 0; w < WAYS; w++) begin
         if (line_rank[base+w] > old_rank) begin
            line_rank[base+w] = line_rank[base+w] - 2'd1;
         end
      end
      line_rank[base+way]   = 2'(WAYS - 1);
      outcome.way_used      = way[cdir_pkg::WAY_OUT_W-1:0];
      outcome.write_through = (op == cdir_pkg::OP_WRITE) && !mode.write_back_mode;
      return outcome;
   endfunction

   function automatic logic [cdir_pkg::ADDR_W-1:0] random_address();
      logic [TAG_W-1:0]       tag_choices [6];
      logic [SET_BITS-1:0]    set_choices [4];
      logic [OFFSET_BITS-1:0] offset;
      tag_choices = '{20'h00000, 20'hFFFFF, 20'h00001, 20'h80000, 20'h7FFFF, 20'h00002};
      set_choices = '{6'd0, 6'd1, 6'd62, 6'd63};
      offset      = OFFSET_BITS'($urandom_range(0, 63));
      if ($urandom_range(0, 9) < 3) begin
         return $urandom();
      end
      return {tag_choices[$urandom_range(0, 5)], set_choices[$urandom_range(0, 3)], offset};
   endfunction

   function automatic cdir_pkg::opcode_type random_opcode();
      return $urandom_range(0, 1) ? cdir_pkg::OP_WRITE : cdir_pkg::OP_READ;
   endfunction

   function automatic void check_field(string name, logic [cdir_pkg::ADDR_W-1:0] want,
                                       logic [cdir_pkg::ADDR_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   task automatic send_access(cdir_pkg::opcode_type op, logic [cdir_pkg::ADDR_W-1:0] addr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_address <= addr;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_outcomes.push_back(directory_lookup(op, addr));
   endtask

   task automatic wait_for_outstanding();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [cdir_pkg::CSR_INDEX_W-1:0] index, logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == cdir_pkg::CSR_WRITE_BACK_MODE) begin
         mode.write_back_mode = value;
      end else begin
         mode.allocate_on_write = value;
      end
   endtask

   task automatic set_mode(logic write_back, logic allocate);
      wait_for_outstanding();
      write_register(cdir_pkg::CSR_WRITE_BACK_MODE, write_back);
      write_register(cdir_pkg::CSR_ALLOCATE_ON_WRITE, allocate);
   endtask

   task automatic test_directed_replacement();
      send_access(cdir_pkg::OP_READ,  32'h0000_0000);
      send_access(cdir_pkg::OP_READ,  32'h0000_0025);
      send_access(cdir_pkg::OP_WRITE, 32'h0000_003F);
      send_access(cdir_pkg::OP_READ,  32'h0000_1000);
      send_access(cdir_pkg::OP_WRITE, 32'h0000_2010);
      send_access(cdir_pkg::OP_READ,  32'h0000_3000);
      send_access(cdir_pkg::OP_READ,  32'h0000_1004);
      send_access(cdir_pkg::OP_READ,  32'h0000_4000);
      send_access(cdir_pkg::OP_READ,  32'h0000_5000);
      send_access(cdir_pkg::OP_READ,  32'hFFFF_FFFF);
      send_access(cdir_pkg::OP_WRITE, 32'hFFFF_FFC0);
      send_access(cdir_pkg::OP_READ,  32'hFFFF_F000);
   endtask

   task automatic test_directed_modes();
      set_mode(1'b0, 1'b0);
      send_access(cdir_pkg::OP_WRITE, 32'h8000_0040);
      send_access(cdir_pkg::OP_WRITE, 32'hFFFF_FFFF);
      send_access(cdir_pkg::OP_READ,  32'h8000_0040);
      send_access(cdir_pkg::OP_WRITE, 32'h8000_0044);
      set_mode(1'b0, 1'b1);
      send_access(cdir_pkg::OP_WRITE, 32'h7FFF_F040);
      send_access(cdir_pkg::OP_WRITE, 32'h0123_4040);
      send_access(cdir_pkg::OP_READ,  32'h0567_8040);
      send_access(cdir_pkg::OP_READ,  32'h0ABC_D040);
      set_mode(1'b1, 1'b1);
      send_access(cdir_pkg::OP_READ,  32'h0FED_C040);
   endtask

   // The long hold on the response side lets the block fill up and raise req_stall.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_cycles   = 300;
      repeat (60) send_access(random_opcode(), random_address());
      wait_for_outstanding();
      repeat (40) send_access(random_opcode(), random_address());
   endtask

   task automatic test_random_traffic(logic write_back, logic allocate, int idle_pct,
                                      int stall_idle_pct, int count);
      set_mode(write_back, allocate);
      send_idle_pct = idle_pct;
      stall_pct     = stall_idle_pct;
      repeat (count) send_access(random_opcode(), random_address());
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_outcomes.size() == 0) begin
            $error("response transfer with no access outstanding");
            error_count++;
         end else begin
            expected_rsp = pending_outcomes.pop_front();
            check_field("hit", expected_rsp.hit, rsp_hit);
            check_field("way_used", expected_rsp.way_used, rsp_way_used);
            check_field("fill_request", expected_rsp.fill_request, rsp_fill_request);
            check_field("victim_writeback", expected_rsp.victim_writeback,
                        rsp_victim_writeback);
            check_field("victim_address", expected_rsp.victim_address, rsp_victim_address);
            check_field("write_through", expected_rsp.write_through, rsp_write_through);
            check_field("write_around", expected_rsp.write_around, rsp_write_around);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = cdir_pkg::OP_READ;
      req_address      = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = cdir_pkg::CSR_WRITE_BACK_MODE;
      csr_write_data   = 1'b0;
      mode             = '{write_back_mode: 1'b1, allocate_on_write: 1'b1};
      for (int i = 0; i < LINES; i++) begin
         line_present[i]  = 1'b0;
         line_modified[i] = 1'b0;
         line_tag_copy[i] = '0;
         line_rank[i]     = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_replacement();
      test_directed_modes();
      test_back_pressure();
      test_random_traffic(1'b1, 1'b1, 0, 0, 457);
      test_random_traffic(1'b0, 1'b1, 52, 0, 457);
      test_random_traffic(1'b1, 1'b0, 0, 52, 457);
      test_random_traffic(1'b0, 1'b0, 34, 34, 457);
      wait_for_outstanding();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
